// ===== sv/tcc_pkg.sv =====
// Package for the triple coprime counter: widths, register indexes, microcode
// opcodes, jump conditions and the control store of the sequencer.
// No dependencies; used by tcc_sequencer, tcc_datapath and triple_coprime_counter.
package tcc_pkg;

    // Default operand width and fixed widths
    localparam int VALUE_BITS_DEF = 31;
    localparam int CNT_BITS       = 32;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_BITS      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_START_COPRIME = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_TOTAL   = 1'd1;

    // Datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NOP    = 3'd0;
    localparam t_op OP_LOAD   = 3'd1;
    localparam t_op OP_STEP   = 3'd2;
    localparam t_op OP_MERGE  = 3'd3;
    localparam t_op OP_FINISH = 3'd4;

    // Jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_ALWAYS   = 3'd0;
    localparam t_cond C_NO_INPUT = 3'd1;
    localparam t_cond C_ZERO     = 3'd2;
    localparam t_cond C_NEQ      = 3'd3;
    localparam t_cond C_OUT_BUSY = 3'd4;

    typedef logic [STEP_BITS-1:0] t_step;

    // Program addresses
    localparam t_step ST_IDLE   = 3'd0;
    localparam t_step ST_CHECK  = 3'd1;
    localparam t_step ST_GCD_AB = 3'd2;
    localparam t_step ST_MERGE  = 3'd3;
    localparam t_step ST_GCD_C  = 3'd6;
    localparam t_step ST_FINISH = 3'd7;

    // One control word: operation, jump condition, jump target.
    // Without a taken jump the step counter advances by one (and wraps).
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ucode;

    // Status flags from the datapath back to the sequencer
    typedef struct packed {
        logic zero;      // an operand of the current triple is zero
        logic neq;       // the two GCD working values differ
        logic out_busy;  // output register full and not taken this cycle
    } t_dp_status;

    // Control store
    function automatic t_ucode ucode_rom(input t_step addr);
        t_ucode w;
        unique case (addr)
            ST_IDLE:   w = '{op: OP_LOAD,   cond: C_NO_INPUT, target: ST_IDLE};
            ST_CHECK:  w = '{op: OP_NOP,    cond: C_ZERO,     target: ST_FINISH};
            ST_GCD_AB: w = '{op: OP_STEP,   cond: C_NEQ,      target: ST_GCD_AB};
            ST_MERGE:  w = '{op: OP_MERGE,  cond: C_ALWAYS,   target: ST_GCD_C};
            ST_GCD_C:  w = '{op: OP_STEP,   cond: C_NEQ,      target: ST_GCD_C};
            ST_FINISH: w = '{op: OP_FINISH, cond: C_OUT_BUSY, target: ST_FINISH};
            default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/tcc_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on tcc_pkg.
module tcc_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tcc_pkg::t_dp_status i_status,
    output tcc_pkg::t_op        o_op,
    output logic                o_in_ready
);

    tcc_pkg::t_step  r_step;
    tcc_pkg::t_step  n_step;
    tcc_pkg::t_ucode w_word;
    logic            w_jump;

    assign w_word = tcc_pkg::ucode_rom(r_step);

    // Evaluate the jump condition
    always_comb begin
        unique case (w_word.cond)
            tcc_pkg::C_ALWAYS:   w_jump = 1'b1;
            tcc_pkg::C_NO_INPUT: w_jump = ~i_in_valid;
            tcc_pkg::C_ZERO:     w_jump = i_status.zero;
            tcc_pkg::C_NEQ:      w_jump = i_status.neq;
            tcc_pkg::C_OUT_BUSY: w_jump = i_status.out_busy;
            default:             w_jump = 1'b1;
        endcase
    end

    assign n_step = w_jump ? w_word.target : tcc_pkg::t_step'(r_step + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tcc_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op       = w_word.op;
    assign o_in_ready = (w_word.op == tcc_pkg::OP_LOAD);

`ifndef SYNTHESIS
    // An accepted triple always moves on to the zero check
    a_load_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == tcc_pkg::ST_IDLE && i_in_valid) |=> (r_step == tcc_pkg::ST_CHECK))
        else $error("accepted triple did not reach zero check");

    // Finish step waits while the output register is blocked
    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_word.op == tcc_pkg::OP_FINISH && i_status.out_busy)
        |=> (r_step == tcc_pkg::ST_FINISH))
        else $error("finish step left while output blocked");
`endif

endmodule

// ===== sv/tcc_datapath.sv =====
// Datapath: binary GCD working registers, saturating tallies and the output
// register. Driven one operation per cycle by the sequencer. Depends on tcc_pkg.
module tcc_datapath #(
    parameter int VALUE_BITS = tcc_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tcc_pkg::t_op                       i_op,
    input  logic                               i_in_valid,
    input  logic [VALUE_BITS-1:0]              i_first,
    input  logic [VALUE_BITS-1:0]              i_second,
    input  logic [VALUE_BITS-1:0]              i_third,
    input  logic                               i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tcc_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output tcc_pkg::t_dp_status                o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_is_coprime,
    output logic [VALUE_BITS-1:0]              o_gcd,
    output logic [tcc_pkg::CNT_BITS-1:0]       o_coprime_cnt,
    output logic [tcc_pkg::CNT_BITS-1:0]       o_total_cnt
);

    localparam int KW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]        r_x, r_y, r_c;
    logic [KW-1:0]                r_k;
    logic                         r_zero;
    logic                         r_out_valid;
    logic                         r_is_coprime;
    logic [VALUE_BITS-1:0]        r_gcd;
    logic [tcc_pkg::CNT_BITS-1:0] r_coprime_tally, r_total_tally;

    logic [VALUE_BITS-1:0]        w_shifted, w_diff_xy, w_diff_yx, w_gcd;
    logic                         w_neq, w_x_even, w_y_even, w_x_gt_y;
    logic                         w_out_busy, w_load, w_finish, w_coprime;
    logic [tcc_pkg::CNT_BITS-1:0] w_coprime_inc, w_total_inc;

    // Compare/subtract and the shift that restores common factors of two
    assign w_neq     = (r_x != r_y);
    assign w_x_even  = ~r_x[0];
    assign w_y_even  = ~r_y[0];
    assign w_x_gt_y  = (r_x > r_y);
    assign w_diff_xy = r_x - r_y;
    assign w_diff_yx = r_y - r_x;
    assign w_shifted = r_x << r_k;

    assign w_out_busy = r_out_valid & ~i_out_ready;
    assign w_load     = (i_op == tcc_pkg::OP_LOAD) & i_in_valid;
    assign w_finish   = (i_op == tcc_pkg::OP_FINISH) & ~w_out_busy;

    // Any zero operand reports divisor one
    assign w_gcd     = r_zero ? VALUE_BITS'(1) : w_shifted;
    assign w_coprime = (w_gcd == VALUE_BITS'(1));

    assign w_coprime_inc = (r_coprime_tally == '1) ? r_coprime_tally
                         : tcc_pkg::CNT_BITS'(r_coprime_tally + 1'b1);
    assign w_total_inc   = (r_total_tally == '1) ? r_total_tally
                         : tcc_pkg::CNT_BITS'(r_total_tally + 1'b1);

    // GCD working registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x    <= i_first;
            r_y    <= i_second;
            r_c    <= i_third;
            r_k    <= '0;
            r_zero <= (i_first == '0) | (i_second == '0) | (i_third == '0);
        end else if (i_op == tcc_pkg::OP_MERGE) begin
            r_x <= w_shifted;
            r_y <= r_c;
            r_k <= '0;
        end else if (i_op == tcc_pkg::OP_STEP && w_neq) begin
            if (w_x_even && w_y_even) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= KW'(r_k + 1'b1);
            end else if (w_x_even) begin
                r_x <= r_x >> 1;
            end else if (w_y_even) begin
                r_y <= r_y >> 1;
            end else if (w_x_gt_y) begin
                r_x <= w_diff_xy >> 1;
            end else begin
                r_y <= w_diff_yx >> 1;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_is_coprime <= w_coprime;
            r_gcd        <= w_gcd;
        end
    end

    // Output valid and tallies; a start write reloads its tally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_coprime_tally <= '0;
            r_total_tally   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tcc_pkg::REG_START_COPRIME: r_coprime_tally <= i_cfg_wdata;
                    tcc_pkg::REG_START_TOTAL:   r_total_tally   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_finish) begin
                r_out_valid   <= 1'b1;
                r_total_tally <= w_total_inc;
                if (w_coprime) begin
                    r_coprime_tally <= w_coprime_inc;
                end
            end
        end
    end

    assign o_status      = '{zero: r_zero, neq: w_neq, out_busy: w_out_busy};
    assign o_out_valid   = r_out_valid;
    assign o_is_coprime  = r_is_coprime;
    assign o_gcd         = r_gcd;
    assign o_coprime_cnt = r_coprime_tally;
    assign o_total_cnt   = r_total_tally;

`ifndef SYNTHESIS
    // A result only appears from a finish step
    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid && $past(i_rst_n))
        |-> $past(i_op == tcc_pkg::OP_FINISH))
        else $error("output valid without finish step");

    // Binary GCD never sees a zero working value
    a_nonzero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == tcc_pkg::OP_STEP && !r_zero) |-> (r_x != '0 && r_y != '0))
        else $error("zero operand inside GCD loop");

    // Total tally moves by at most one unless reloaded
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_we))
        |-> (r_total_tally == $past(r_total_tally)
             || r_total_tally == tcc_pkg::CNT_BITS'($past(r_total_tally) + 1'b1)))
        else $error("total tally jumped");
`endif

endmodule

// ===== sv/triple_coprime_counter.sv =====
// Top level of the triple coprime counter: stream ports, field packing, and
// the microcode sequencer driving the GCD datapath. Depends on tcc_pkg,
// tcc_sequencer and tcc_datapath.
//
// Usage:
//   s_axis carries one triple per transfer; m_axis returns one result per
//   triple: coprime flag, GCD (1 if any operand is zero), and the coprime and
//   total tallies including this triple, both saturating at all ones.
//   i_cfg_we/i_cfg_idx/i_cfg_wdata load a start value: index 0 the coprime
//   tally, index 1 the total tally. Write only while the block is idle.
//   One triple at a time. A triple is accepted, checked for a zero operand,
//   then takes one binary GCD step per cycle for (first, second), then
//   (result, third), and ends with a finish step. A zero operand skips both
//   loops. The result is valid the cycle after the finish step; the next
//   triple is accepted in that cycle even if m_axis stalls. A result still
//   held at the next finish step holds the sequencer there.
//   Synchronous active-low reset clears the sequencer, output valid and tallies.
module triple_coprime_counter #(
    parameter int VALUE_BITS = tcc_pkg::VALUE_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // first_value, second_value, third_value from bit 0 up
    input  logic [((3*VALUE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // is_coprime, common_divisor, coprime_count, total_count from bit 0 up
    output logic [((VALUE_BITS+2*32+8)/8)*8-1:0]     m_axis_tdata,
    input  logic                                     i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_BITS-1:0]         i_cfg_idx,
    input  logic [tcc_pkg::CFG_DATA_BITS-1:0]        i_cfg_wdata
);

    localparam int OUT_W = ((VALUE_BITS + 2*tcc_pkg::CNT_BITS + 8) / 8) * 8;

    tcc_pkg::t_op                 w_op;
    tcc_pkg::t_dp_status          w_status;
    logic                         w_is_coprime;
    logic [VALUE_BITS-1:0]        w_gcd;
    logic [tcc_pkg::CNT_BITS-1:0] w_coprime_cnt, w_total_cnt;

    tcc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_op       (w_op),
        .o_in_ready (s_axis_tready)
    );

    tcc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_in_valid    (s_axis_tvalid),
        .i_first       (s_axis_tdata[VALUE_BITS-1:0]),
        .i_second      (s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .i_third       (s_axis_tdata[3*VALUE_BITS-1:2*VALUE_BITS]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_status      (w_status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_is_coprime  (w_is_coprime),
        .o_gcd         (w_gcd),
        .o_coprime_cnt (w_coprime_cnt),
        .o_total_cnt   (w_total_cnt)
    );

    // Pack result fields, zero padded to whole bytes
    assign m_axis_tdata = OUT_W'({w_total_cnt, w_coprime_cnt, w_gcd, w_is_coprime});

endmodule

// ===== verif/triple_coprime_counter_tb.sv =====
// Self-checking testbench for triple_coprime_counter: directed triples, then
// random triples under several start-count settings, with random stalls on both streams.
// Depends on tcc_pkg and the triple_coprime_counter RTL.
`timescale 1ns / 1ps

module triple_coprime_counter_tb;

    localparam int VB       = tcc_pkg::VALUE_BITS_DEF;
    localparam int CW       = tcc_pkg::CNT_BITS;
    localparam int S_BITS   = ((3*VB+7)/8)*8;
    localparam int M_BITS   = ((VB+2*32+8)/8)*8;
    localparam logic [VB-1:0] VMAX = {VB{1'b1}};
    localparam logic [CW-1:0] CNT_FULL = {CW{1'b1}};
    localparam int MAX_GAP  = 17;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 200;
    localparam int NDIR     = 20;

    // One result, laid out as on m_axis_tdata (lowest field last)
    typedef struct packed {
        logic [CW-1:0] total_count;
        logic [CW-1:0] coprime_count;
        logic [VB-1:0] common_divisor;
        logic          is_coprime;
    } t_triple_result;

    // Directed row: operands, and a hand-written flag/divisor where obvious
    typedef struct packed {
        logic [VB-1:0] a;
        logic [VB-1:0] b;
        logic [VB-1:0] c;
        logic          typed;
        logic          cop;
        logic [VB-1:0] gcd;
    } t_directed_row;

    localparam t_directed_row DIRECTED [NDIR] = '{
        '{31'd0, 31'd0, 31'd0, 1'b1, 1'b1, 31'd1},
        '{31'd0, 31'd5, 31'd10, 1'b1, 1'b1, 31'd1},
        '{31'd6, 31'd0, 31'd9, 1'b1, 1'b1, 31'd1},
        '{31'd4, 31'd8, 31'd0, 1'b1, 1'b1, 31'd1},
        '{31'd1, 31'd1, 31'd1, 1'b1, 1'b1, 31'd1},
        '{VMAX, VMAX, VMAX, 1'b1, 1'b0, VMAX},
        '{VMAX, 31'd1, VMAX, 1'b1, 1'b1, 31'd1},
        '{31'd12, 31'd18, 31'd24, 1'b1, 1'b0, 31'd6},
        '{31'h4000_0000, 31'h4000_0000, 31'h4000_0000, 1'b1, 1'b0, 31'h4000_0000},
        '{31'h4000_0000, 31'h6000_0000, 31'h2000_0000, 1'b1, 1'b0, 31'h2000_0000},
        '{31'd7, 31'd7, 31'd7, 1'b1, 1'b0, 31'd7},
        '{31'd15, 31'd25, 31'd35, 1'b1, 1'b0, 31'd5},
        '{31'd17, 31'd19, 31'd23, 1'b1, 1'b1, 31'd1},
        '{VMAX, VMAX - 31'd1, VMAX, 1'b1, 1'b1, 31'd1},
        '{31'd2147483646, 31'd1073741823, 31'd715827882, 1'b0, 1'b0, 31'd0},
        '{31'h2AAA_AAAA, 31'h5555_5555, VMAX, 1'b0, 1'b0, 31'd0},
        '{31'd1134903170, 31'd1836311903, 31'd3, 1'b1, 1'b1, 31'd1},
        '{31'd2, 31'd4, 31'd6, 1'b1, 1'b0, 31'd2},
        '{31'd1, 31'h4000_0000, VMAX, 1'b1, 1'b1, 31'd1},
        '{31'h5555_5554, 31'h2AAA_AAAA, 31'h0000_0006, 1'b0, 1'b0, 31'd0}
    };

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [S_BITS-1:0]                     s_axis_tdata = '0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [M_BITS-1:0]                     m_axis_tdata;
    logic                                  i_cfg_we = 1'b0;
    logic [tcc_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx = tcc_pkg::REG_START_COPRIME;
    logic [tcc_pkg::CFG_DATA_BITS-1:0]     i_cfg_wdata = '0;

    // Predictor state and bookkeeping
    logic [CW-1:0]       coprime_tally = '0;
    logic [CW-1:0]       triple_tally = '0;
    t_triple_result      pending_results[$];
    bit  src_steady = 1'b0;
    bit  sink_steady = 1'b0;
    bit  hold_off_req = 1'b0;
    int  errors = 0;
    int  triples_sent = 0;
    int  results_checked = 0;
    int  coprime_seen = 0;
    int  zero_operand_seen = 0;
    int  saturated_seen = 0;
    int  start_loads = 0;
    int  hold_offs = 0;

    triple_coprime_counter #(.VALUE_BITS(VB)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Euclid on two operands
    function automatic logic [VB-1:0] euclid(input logic [VB-1:0] x, input logic [VB-1:0] y);
        logic [VB-1:0] r;
        while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Predict one result and advance the saturating tallies
    function automatic t_triple_result tally_triple(input logic [VB-1:0] a,
                                                    input logic [VB-1:0] b,
                                                    input logic [VB-1:0] c);
        t_triple_result r;
        logic [VB-1:0]  g;
        if (a == '0 || b == '0 || c == '0) begin
            g = VB'(1);
        end else begin
            g = euclid(euclid(a, b), c);
        end
        r.is_coprime = (g == VB'(1));
        if (r.is_coprime && coprime_tally != CNT_FULL) begin
            coprime_tally = coprime_tally + 1'b1;
        end
        if (triple_tally != CNT_FULL) begin
            triple_tally = triple_tally + 1'b1;
        end
        r.common_divisor = g;
        r.coprime_count  = coprime_tally;
        r.total_count    = triple_tally;
        return r;
    endfunction

    // Offer one triple after a random gap; record the expectation on transfer
    task automatic offer_triple(input logic [VB-1:0] a, input logic [VB-1:0] b,
                                input logic [VB-1:0] c, input bit typed,
                                input bit t_cop, input logic [VB-1:0] t_gcd);
        int gap;
        t_triple_result want;
        if ($urandom_range(0, 39) == 0) begin
            src_steady = ~src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_BITS-3*VB){1'b0}}, c, b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = tally_triple(a, b, c);
        if (typed) begin
            want.is_coprime     = t_cop;
            want.common_divisor = t_gcd;
        end
        if (a == '0 || b == '0 || c == '0) begin
            zero_operand_seen++;
        end
        pending_results.push_back(want);
        triples_sent++;
    endtask

    // Load start counts once every outstanding result has been returned
    task automatic load_start_counts(input bit set_cop, input logic [CW-1:0] cop,
                                     input bit set_tot, input logic [CW-1:0] tot);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        if (set_cop) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= tcc_pkg::REG_START_COPRIME;
            i_cfg_wdata <= cop;
            @(posedge i_clk);
            coprime_tally = cop;
            start_loads++;
        end
        if (set_tot) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= tcc_pkg::REG_START_TOTAL;
            i_cfg_wdata <= tot;
            @(posedge i_clk);
            triple_tally = tot;
            start_loads++;
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random operand triple; mostly shaped to give non-trivial divisors
    task automatic draw_triple(output logic [VB-1:0] a, output logic [VB-1:0] b,
                               output logic [VB-1:0] c);
        logic [VB-1:0] g;
        int kind;
        kind = $urandom_range(0, 9);
        case (kind) inside
            [0:2]: begin
                a = VB'($urandom());
                b = VB'($urandom());
                c = VB'($urandom());
            end
            [3:5]: begin
                // shared factor of modest size
                g = VB'($urandom_range(2, 1 << $urandom_range(1, 16)));
                a = VB'(g * $urandom_range(1, VMAX / g));
                b = VB'(g * $urandom_range(1, VMAX / g));
                c = VB'(g * $urandom_range(1, VMAX / g));
            end
            6: begin
                // large shared factor, small multipliers
                g = VB'($urandom_range(2, VMAX / 2));
                a = VB'(g * $urandom_range(1, VMAX / g));
                b = VB'(g * $urandom_range(1, VMAX / g));
                c = VB'(g * $urandom_range(1, VMAX / g));
            end
            7: begin
                a = VB'($urandom_range(0, 12));
                b = VB'($urandom_range(0, 12));
                c = VB'($urandom_range(0, 12));
            end
            8: begin
                // one operand zero
                a = VB'($urandom());
                b = VB'($urandom());
                c = VB'($urandom());
                case ($urandom_range(0, 2))
                    0: a = '0;
                    1: b = '0;
                    default: c = '0;
                endcase
            end
            default: begin
                // near the top of the range, values with trailing zero bits
                a = VMAX - VB'($urandom_range(0, 3));
                b = VMAX << $urandom_range(0, VB - 1);
                c = VB'($urandom()) << $urandom_range(0, 8);
            end
        endcase
    endtask

    task automatic run_random(input int count, input int hold_at);
        logic [VB-1:0] a, b, c;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_off_req = 1'b1;
            end
            draw_triple(a, b, c);
            offer_triple(a, b, c, 1'b0, 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string name, input logic [CW-1:0] want,
                                        input logic [CW-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $realtime, name, want, got);
            errors++;
        end
    endfunction

    // Result side: random stalls, one long hold-off on request, field checks
    initial begin : result_sink
        int stall;
        t_triple_result got;
        t_triple_result want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                sink_steady = ~sink_steady;
            end
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got = m_axis_tdata[$bits(t_triple_result)-1:0];
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual 0x%024h",
                         $realtime, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("is_coprime", CW'(want.is_coprime), CW'(got.is_coprime));
                check_field("common_divisor", CW'(want.common_divisor),
                            CW'(got.common_divisor));
                check_field("coprime_count", want.coprime_count, got.coprime_count);
                check_field("total_count", want.total_count, got.total_count);
                results_checked++;
                if (got.is_coprime) begin
                    coprime_seen++;
                end
                if (got.total_count == CNT_FULL) begin
                    saturated_seen++;
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed triples, tallies from reset
        for (int i = 0; i < NDIR; i++) begin
            offer_triple(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].c,
                         DIRECTED[i].typed, DIRECTED[i].cop, DIRECTED[i].gcd);
        end

        // random start counts; long receiver hold-off early on
        load_start_counts(1'b1, $urandom(), 1'b1, $urandom());
        run_random(300, 50);
        // both tallies a few steps short of saturation
        load_start_counts(1'b1, 32'hFFFF_FFF0, 1'b1, 32'hFFFF_FFF8);
        run_random(40, -1);
        // restart only the total tally; the coprime tally carries on near the top
        load_start_counts(1'b0, '0, 1'b1, '0);
        run_random(300, -1);
        load_start_counts(1'b1, '0, 1'b1, '0);
        run_random(300, -1);
        load_start_counts(1'b1, CNT_FULL, 1'b1, CNT_FULL);
        run_random(30, -1);
        // restart only the coprime tally
        load_start_counts(1'b1, $urandom(), 1'b0, '0);
        run_random(280, -1);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d triples sent, %0d results checked, %0d coprime, %0d with a zero operand",
                 triples_sent, results_checked, coprime_seen, zero_operand_seen);
        $display("Run: %0d start-count loads, %0d saturated totals, %0d long hold-offs, %0d errors",
                 start_loads, saturated_seen, hold_offs, errors);
        if (errors == 0) begin
            $display("triple_coprime_counter_tb: done, clean");
        end else begin
            $display("triple_coprime_counter_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("Timeout: %0d results still outstanding", pending_results.size());
        $display("triple_coprime_counter_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tcc_pkg.sv
sv/tcc_sequencer.sv
sv/tcc_datapath.sv
sv/triple_coprime_counter.sv
verif/triple_coprime_counter_tb.sv
